### rtl/kod_pkg.sv
// Package for the keyed object dictionary: sizes, codes, item types and helpers.
package kod_pkg;

    localparam int TABLE_ENTRIES = 32;
    localparam int MAX_BYTES     = 8;
    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

    typedef enum logic [1:0] {
        CMD_ADD   = 2'd0,
        CMD_READ  = 2'd1,
        CMD_WRITE = 2'd2,
        CMD_NONE  = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        ST_OK            = 3'd0,
        ST_OUT_OF_MEMORY = 3'd1,
        ST_INCOMPATIBLE  = 3'd2,
        ST_NOT_FOUND     = 3'd3,
        ST_WRITE_ONLY    = 3'd4,
        ST_READ_ONLY     = 3'd5,
        ST_TOO_LONG      = 3'd6,
        ST_TOO_SHORT     = 3'd7
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FETCH,
        S_DECIDE
    } t_state;

    typedef struct packed {
        logic [1:0]  command;
        logic [23:0] object_key;
        logic        may_read;
        logic        may_write;
        logic [3:0]  data_length;
        logic [63:0] data_value;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  status;
        logic [63:0] read_data;
        logic [3:0]  byte_count;
    } t_out_item;

    // bit 0 of access: readable, bit 1: writable
    typedef struct packed {
        logic [23:0] key;
        logic [1:0]  access;
        logic [3:0]  length;
    } t_entry;

    function automatic logic [63:0] byte_mask(input logic [3:0] nbytes);
        logic [63:0] m;
        m = '0;
        for (int b = 0; b < 8; b++) begin
            if (4'(b) < nbytes) begin
                m[b*8 +: 8] = 8'hFF;
            end
        end
        return m;
    endfunction

endpackage

### rtl/keyed_object_dictionary.sv
// Keyed object dictionary: entry table in two memories, scanned one key per cycle.
//
//  channel | direction | handshake          | payload
//  in      | input     | i_in_valid/o_in_stall  | i_in_item (t_in_item)
//  out     | output    | o_out_valid/i_out_stall| o_out_item (t_out_item)
//  cfg     | input     | i_cfg_valid/o_cfg_ready| i_cfg_data (table_frozen)
//
// Each item passes S_SCAN, S_FETCH, S_DECIDE; the scan stops early at a matching key:
// it reads one entry per cycle from the key memory, S_FETCH reads the value memory,
// S_DECIDE decides, writes back once the output is free. One item is worked at a time.
// Reset clears the entry count and the frozen flag; memory contents need no clearing.
// A result waits in the output register while the next item is already accepted.
module keyed_object_dictionary (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  kod_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output kod_pkg::t_out_item o_out_item,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic               i_cfg_data
);
    import kod_pkg::*;

    t_entry      key_mem [TABLE_ENTRIES];
    logic [63:0] val_mem [TABLE_ENTRIES];

    t_state      r_state, n_state;
    logic        r_frozen;
    logic [CNT_W-1:0] r_count, n_count;
    logic [CNT_W-1:0] r_addr, n_addr;
    logic        r_pend, n_pend;
    logic        r_found, n_found;
    logic [IDX_W-1:0] r_slot, n_slot;
    t_entry      r_meta, n_meta;
    t_in_item    r_item;
    t_entry      r_rd_entry;
    logic [63:0] r_rd_value;
    logic        r_out_valid, n_out_valid;
    t_out_item   r_out, n_out;

    logic        key_we, val_we;
    logic [IDX_W-1:0] wr_idx;
    t_entry      wr_entry;
    logic [63:0] wr_value;
    logic        match, out_free, accept;
    logic [CNT_W-1:0] prev_addr;

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    assign accept    = i_in_valid && (r_state == S_IDLE);
    assign out_free  = !r_out_valid || !i_out_stall;
    assign match     = r_pend && (r_rd_entry.key == r_item.object_key);
    assign prev_addr = r_addr - CNT_W'(1);

    always_ff @(posedge i_clk) begin
        r_rd_entry <= key_mem[r_addr[IDX_W-1:0]];
        r_rd_value <= val_mem[r_slot];
        if (key_we) begin
            key_mem[wr_idx] <= wr_entry;
        end
        if (val_we) begin
            val_mem[wr_idx] <= wr_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_frozen    <= 1'b0;
            r_count     <= '0;
            r_addr      <= '0;
            r_pend      <= 1'b0;
            r_found     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_addr      <= n_addr;
            r_pend      <= n_pend;
            r_found     <= n_found;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid) begin
                r_frozen <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_slot <= n_slot;
        r_meta <= n_meta;
        r_out  <= n_out;
        if (accept) begin
            r_item <= i_in_item;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_addr      = r_addr;
        n_pend      = r_pend;
        n_found     = r_found;
        n_slot      = r_slot;
        n_meta      = r_meta;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_out_stall;
        key_we      = 1'b0;
        val_we      = 1'b0;
        wr_idx      = r_slot;
        wr_entry.key    = r_item.object_key;
        wr_entry.access = {r_item.may_write, r_item.may_read};
        wr_entry.length = r_item.data_length;
        wr_value    = r_item.data_value & byte_mask(r_item.data_length);

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_SCAN;
                    n_addr  = '0;
                    n_pend  = 1'b0;
                    n_found = 1'b0;
                end
            end
            S_SCAN: begin
                if (match) begin
                    n_found = 1'b1;
                    n_slot  = prev_addr[IDX_W-1:0];
                    n_meta  = r_rd_entry;
                    n_state = S_FETCH;
                end else if (r_addr == r_count) begin
                    n_found = 1'b0;
                    n_state = S_FETCH;
                end else begin
                    n_pend = 1'b1;
                    n_addr = r_addr + CNT_W'(1);
                end
            end
            S_FETCH: begin
                n_state = S_DECIDE;
            end
            S_DECIDE: begin
                if (out_free) begin
                    n_state          = S_IDLE;
                    n_out_valid      = 1'b1;
                    n_out.status     = ST_OK;
                    n_out.read_data  = '0;
                    n_out.byte_count = '0;
                    case (t_cmd'(r_item.command))
                        CMD_ADD: begin
                            if (r_frozen || r_item.data_length == 4'd0
                                || r_item.data_length > 4'(MAX_BYTES)
                                || r_count == CNT_W'(TABLE_ENTRIES)) begin
                                n_out.status = ST_OUT_OF_MEMORY;
                            end else if (r_found) begin
                                n_out.status = ST_INCOMPATIBLE;
                            end else begin
                                wr_idx  = r_count[IDX_W-1:0];
                                key_we  = 1'b1;
                                val_we  = 1'b1;
                                n_count = r_count + CNT_W'(1);
                            end
                        end
                        CMD_READ: begin
                            if (!r_found) begin
                                n_out.status = ST_NOT_FOUND;
                            end else if (!r_meta.access[0]) begin
                                n_out.status = ST_WRITE_ONLY;
                            end else if (r_item.data_length < r_meta.length) begin
                                n_out.status = ST_OUT_OF_MEMORY;
                            end else begin
                                n_out.read_data  = r_rd_value & byte_mask(r_meta.length);
                                n_out.byte_count = r_meta.length;
                            end
                        end
                        CMD_WRITE: begin
                            if (!r_found) begin
                                n_out.status = ST_NOT_FOUND;
                            end else if (!r_meta.access[1]) begin
                                n_out.status = ST_READ_ONLY;
                            end else if (r_item.data_length > r_meta.length) begin
                                n_out.status = ST_TOO_LONG;
                            end else if (r_item.data_length < r_meta.length) begin
                                n_out.status = ST_TOO_SHORT;
                            end else begin
                                val_we = 1'b1;
                            end
                        end
                        default: begin
                            n_out.status = ST_INCOMPATIBLE;
                        end
                    endcase
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

### test/tb_keyed_object_dictionary.sv
// Testbench for keyed_object_dictionary: directed and random commands checked by a scoreboard.
`timescale 1ns / 100ps

module tb_keyed_object_dictionary;
    import kod_pkg::*;

    localparam int CLK_PERIOD  = 12;
    localparam int IDLE_LIMIT  = 2000;
    localparam int POOL_SIZE   = 48;
    localparam int DRAIN_WAIT  = 50;
    localparam int LONG_HOLD   = 300;
    localparam int HOLD_AT     = 300;

    class dictionary_scoreboard;
        t_out_item   expected_replies[$];
        int          errors;
        bit          frozen;
        int          n_entries;
        logic [23:0] slot_key   [TABLE_ENTRIES];
        logic [1:0]  slot_access[TABLE_ENTRIES];
        logic [3:0]  slot_len   [TABLE_ENTRIES];
        logic [63:0] slot_value [TABLE_ENTRIES];

        function new();
            errors    = 0;
            frozen    = 1'b0;
            n_entries = 0;
        endfunction

        function void set_frozen(bit v);
            frozen = v;
        endfunction

        function int pending();
            return expected_replies.size();
        endfunction

        function logic [63:0] keep_bytes(logic [3:0] n);
            if (n >= 4'd8) begin
                return '1;
            end
            return (64'd1 << (n * 8)) - 64'd1;
        endfunction

        // lookup in order of insertion; -1 when absent
        function int find_slot(logic [23:0] key);
            for (int i = 0; i < n_entries; i++) begin
                if (slot_key[i] == key) begin
                    return i;
                end
            end
            return -1;
        endfunction

        function void apply_command(t_in_item it);
            t_out_item reply;
            int        slot;
            reply = '0;
            reply.status = ST_OK;
            slot = find_slot(it.object_key);
            case (t_cmd'(it.command))
                CMD_ADD: begin
                    if (frozen || it.data_length == 4'd0 || it.data_length > MAX_BYTES ||
                        n_entries >= TABLE_ENTRIES) begin
                        reply.status = ST_OUT_OF_MEMORY;
                    end else if (slot >= 0) begin
                        reply.status = ST_INCOMPATIBLE;
                    end else begin
                        slot_key[n_entries]    = it.object_key;
                        slot_access[n_entries] = {it.may_write, it.may_read};
                        slot_len[n_entries]    = it.data_length;
                        slot_value[n_entries]  = it.data_value & keep_bytes(it.data_length);
                        n_entries++;
                    end
                end
                CMD_READ: begin
                    if (slot < 0) begin
                        reply.status = ST_NOT_FOUND;
                    end else if (!slot_access[slot][0]) begin
                        reply.status = ST_WRITE_ONLY;
                    end else if (it.data_length < slot_len[slot]) begin
                        reply.status = ST_OUT_OF_MEMORY;
                    end else begin
                        reply.read_data  = slot_value[slot] & keep_bytes(slot_len[slot]);
                        reply.byte_count = slot_len[slot];
                    end
                end
                CMD_WRITE: begin
                    if (slot < 0) begin
                        reply.status = ST_NOT_FOUND;
                    end else if (!slot_access[slot][1]) begin
                        reply.status = ST_READ_ONLY;
                    end else if (it.data_length > slot_len[slot]) begin
                        reply.status = ST_TOO_LONG;
                    end else if (it.data_length < slot_len[slot]) begin
                        reply.status = ST_TOO_SHORT;
                    end else begin
                        slot_value[slot] = it.data_value & keep_bytes(it.data_length);
                    end
                end
                default: begin
                    reply.status = ST_INCOMPATIBLE;
                end
            endcase
            expected_replies.push_back(reply);
        endfunction

        function void check_reply(t_out_item got);
            t_out_item want;
            if (expected_replies.size() == 0) begin
                $display("%0t: unexpected item, expected none actual %h", $time, got);
                errors++;
                return;
            end
            want = expected_replies.pop_front();
            if (got.status !== want.status) begin
                $display("%0t: status mismatch, expected %0d actual %0d",
                         $time, want.status, got.status);
                errors++;
            end
            if (got.read_data !== want.read_data) begin
                $display("%0t: read_data mismatch, expected %h actual %h",
                         $time, want.read_data, got.read_data);
                errors++;
            end
            if (got.byte_count !== want.byte_count) begin
                $display("%0t: byte_count mismatch, expected %0d actual %0d",
                         $time, want.byte_count, got.byte_count);
                errors++;
            end
        endfunction
    endclass

    logic      i_clk     = 1'b0;
    logic      i_rst_n   = 1'b0;
    logic      in_valid  = 1'b0;
    t_in_item  in_item   = '0;
    logic      out_stall = 1'b0;
    logic      cfg_valid = 1'b0;
    logic      cfg_data  = 1'b0;
    logic      o_in_stall;
    logic      o_out_valid;
    t_out_item o_out_item;
    logic      o_cfg_ready;

    dictionary_scoreboard board = new();

    logic [23:0] key_pool[POOL_SIZE];
    logic [3:0]  len_pool[POOL_SIZE];
    bit          no_idle = 1'b0;
    int          replies_taken = 0;

    keyed_object_dictionary u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (o_out_item),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    initial begin
        forever begin
            #(CLK_PERIOD / 2) i_clk = ~i_clk;
        end
    end

    function automatic int draw_wait();
        return no_idle ? 0 : $urandom_range(0, 6);
    endfunction

    function automatic t_in_item make_item(t_cmd cmd, logic [23:0] key, logic rd, logic wr,
                                           logic [3:0] len, logic [63:0] val);
        t_in_item it;
        it.command     = cmd;
        it.object_key  = key;
        it.may_read    = rd;
        it.may_write   = wr;
        it.data_length = len;
        it.data_value  = val;
        return it;
    endfunction

    // mostly keys from the pool with their usual length, so reads and writes get past lookup
    function automatic t_in_item random_item();
        t_in_item it;
        int       r;
        int       pick;
        r    = $urandom_range(0, 99);
        pick = $urandom_range(0, POOL_SIZE - 1);
        it.command = (r < 25) ? CMD_ADD : (r < 60) ? CMD_READ : (r < 95) ? CMD_WRITE : CMD_NONE;
        if ($urandom_range(0, 9) < 8) begin
            it.object_key  = key_pool[pick];
            it.data_length = len_pool[pick];
        end else begin
            it.object_key  = 24'($urandom);
            it.data_length = 4'($urandom_range(0, 15));
        end
        if ($urandom_range(0, 3) == 0) begin
            it.data_length = 4'($urandom_range(0, 15));
        end
        it.may_read   = ($urandom_range(0, 3) != 0);
        it.may_write  = ($urandom_range(0, 3) != 0);
        it.data_value = {$urandom, $urandom};
        return it;
    endfunction

    task automatic push_item(input t_in_item it);
        int gap;
        gap = draw_wait();
        repeat (gap) begin
            @(negedge i_clk);
            in_valid = 1'b0;
        end
        @(negedge i_clk);
        in_valid = 1'b1;
        in_item  = it;
        do begin
            @(posedge i_clk);
        end while (o_in_stall);
        board.apply_command(it);
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        in_valid = 1'b0;
        while (board.pending() != 0) begin
            @(posedge i_clk);
        end
        @(negedge i_clk);
    endtask

    task automatic write_frozen(input bit v);
        wait_drained();
        cfg_valid = 1'b1;
        cfg_data  = v;
        do begin
            @(posedge i_clk);
        end while (!o_cfg_ready);
        board.set_frozen(v);
        @(negedge i_clk);
        cfg_valid = 1'b0;
    endtask

    task automatic random_phase(input bit frozen_v, input bit quiet, input int count);
        write_frozen(frozen_v);
        no_idle = quiet;
        repeat (count) begin
            push_item(random_item());
        end
    endtask

    // receiver: random hold per item, one long hold to back up the input
    initial begin : receiver
        int hold;
        wait (i_rst_n);
        forever begin
            hold = (replies_taken == HOLD_AT) ? LONG_HOLD : draw_wait();
            repeat (hold) begin
                @(negedge i_clk);
                out_stall = 1'b1;
            end
            @(negedge i_clk);
            out_stall = 1'b0;
            do begin
                @(posedge i_clk);
            end while (!o_out_valid);
            board.check_reply(o_out_item);
            replies_taken++;
        end
    end

    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((in_valid && !o_in_stall) || (o_out_valid && !out_stall) ||
                (cfg_valid && o_cfg_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("keyed_object_dictionary test failed");
        $finish;
    end

    initial begin : stimulus
        key_pool[0] = 24'h000000;
        len_pool[0] = 4'd1;
        key_pool[1] = 24'hFFFFFF;
        len_pool[1] = 4'd8;
        for (int i = 2; i < POOL_SIZE; i++) begin
            key_pool[i] = 24'($urandom);
            len_pool[i] = 4'($urandom_range(1, 8));
        end

        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;

        write_frozen(1'b0);
        push_item(make_item(CMD_ADD,   24'h000000, 1'b1, 1'b1, 4'd0,  '1));
        push_item(make_item(CMD_ADD,   24'h000000, 1'b1, 1'b1, 4'd9,  '1));
        push_item(make_item(CMD_ADD,   24'h000000, 1'b1, 1'b1, 4'd15, '1));
        push_item(make_item(CMD_ADD,   24'h000000, 1'b1, 1'b0, 4'd1,  '1));
        push_item(make_item(CMD_ADD,   24'hFFFFFF, 1'b0, 1'b1, 4'd8,  64'hA5A5_5A5A_C3C3_3C3C));
        push_item(make_item(CMD_ADD,   24'h123456, 1'b1, 1'b1, 4'd4,  '1));
        push_item(make_item(CMD_ADD,   24'h000000, 1'b1, 1'b1, 4'd2,  '0));
        push_item(make_item(CMD_ADD,   24'h00FF01, 1'b0, 1'b0, 4'd2,  64'h1234));
        push_item(make_item(CMD_READ,  24'h000000, 1'b0, 1'b0, 4'd0,  '0));
        push_item(make_item(CMD_READ,  24'h000000, 1'b1, 1'b1, 4'd15, '1));
        push_item(make_item(CMD_READ,  24'hFFFFFF, 1'b0, 1'b0, 4'd8,  '0));
        push_item(make_item(CMD_READ,  24'hABCDEF, 1'b0, 1'b0, 4'd8,  '0));
        push_item(make_item(CMD_READ,  24'h123456, 1'b0, 1'b0, 4'd3,  '0));
        push_item(make_item(CMD_READ,  24'h123456, 1'b0, 1'b0, 4'd4,  '0));
        push_item(make_item(CMD_WRITE, 24'hABCDEF, 1'b1, 1'b1, 4'd4,  '1));
        push_item(make_item(CMD_WRITE, 24'h000000, 1'b1, 1'b1, 4'd1,  '1));
        push_item(make_item(CMD_WRITE, 24'h123456, 1'b1, 1'b1, 4'd5,  '1));
        push_item(make_item(CMD_WRITE, 24'h123456, 1'b1, 1'b1, 4'd3,  '1));
        push_item(make_item(CMD_WRITE, 24'h123456, 1'b0, 1'b0, 4'd4,  64'h0123_4567_89AB_CDEF));
        push_item(make_item(CMD_READ,  24'h123456, 1'b0, 1'b0, 4'd8,  '0));
        push_item(make_item(CMD_WRITE, 24'hFFFFFF, 1'b0, 1'b0, 4'd8,  '0));
        push_item(make_item(CMD_READ,  24'hFFFFFF, 1'b1, 1'b1, 4'd8,  '1));
        push_item(make_item(CMD_WRITE, 24'h00FF01, 1'b1, 1'b1, 4'd2,  '1));
        push_item(make_item(CMD_READ,  24'h00FF01, 1'b1, 1'b1, 4'd8,  '1));
        push_item(make_item(CMD_NONE,  24'h123456, 1'b1, 1'b1, 4'd4,  '1));

        random_phase(1'b1, 1'b0, 150);
        random_phase(1'b0, 1'b0, 600);
        random_phase(1'b1, 1'b1, 120);
        random_phase(1'b0, 1'b1, 400);
        random_phase(1'b0, 1'b0, 480);

        wait_drained();
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (board.errors == 0 && board.pending() == 0) begin
            $display("keyed_object_dictionary test passed");
        end else begin
            $display("keyed_object_dictionary test failed");
        end
        $finish;
    end

endmodule

### sim.f
rtl/kod_pkg.sv
rtl/keyed_object_dictionary.sv
test/tb_keyed_object_dictionary.sv
